// ===== src/tsdi_pkg.sv =====
// shared types and constants for the segment drop injector
package tsdi_pkg;

	typedef enum logic [2:0] {
		WHY_NONE   = 3'd0,
		WHY_BITERR = 3'd1,
		WHY_RANDOM = 3'd2,
		WHY_BURST  = 3'd3,
		WHY_BUDGET = 3'd4
	} why_t;

	localparam logic [2:0] CFG_RAND_THR   = 3'd0;
	localparam logic [2:0] CFG_BURST_THR  = 3'd1;
	localparam logic [2:0] CFG_BURST_LEN  = 3'd2;
	localparam logic [2:0] CFG_CLIENT_BUD = 3'd3;
	localparam logic [2:0] CFG_SERVER_BUD = 3'd4;

	localparam int          CFG_DATA_BITS = 32;
	localparam int          THR_BITS      = 17;
	localparam int          LEN_BITS      = 8;
	localparam int          LANES         = 4;

	localparam logic [2:0]  KIND_FIN      = 3'd3;

	typedef struct packed {
		why_t       pre_why;
		logic       burst_hit;
		logic       server_side;
		logic       budget_kind;
		logic [1:0] kind;
	} cls_t;

	localparam int CLS_BITS = $bits(cls_t);

endpackage

// ===== src/tsdi_front.sv =====
// front end: threshold registers and stateless classification of each frame
module tsdi_front #(
	parameter int RAND_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_index,
	input  logic [tsdi_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                bit_error,
	input  logic                                server_side,
	input  logic [2:0]                          seg_kind,
	input  logic [RAND_BITS-1:0]                rand_drop,
	input  logic [RAND_BITS-1:0]                rand_burst,
	output tsdi_pkg::cls_t                      cls
);
	import tsdi_pkg::*;

	localparam int CW = (RAND_BITS > THR_BITS) ? RAND_BITS : THR_BITS;

	logic [THR_BITS-1:0] rand_thr_q;
	logic [THR_BITS-1:0] burst_thr_q;
	logic                random_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rand_thr_q  <= '0;
			burst_thr_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_RAND_THR)
				rand_thr_q <= cfg_data[THR_BITS-1:0];
			if (cfg_index == CFG_BURST_THR)
				burst_thr_q <= cfg_data[THR_BITS-1:0];
		end
	end

	assign random_hit = CW'(rand_drop) < CW'(rand_thr_q);

	always_comb begin
		priority if (bit_error)
			cls.pre_why = WHY_BITERR;
		else if (random_hit)
			cls.pre_why = WHY_RANDOM;
		else
			cls.pre_why = WHY_NONE;
		cls.burst_hit   = CW'(rand_burst) < CW'(burst_thr_q);
		cls.server_side = server_side;
		cls.budget_kind = seg_kind <= KIND_FIN;
		cls.kind        = seg_kind[1:0];
	end

endmodule

// ===== src/tsdi_queue.sv =====
// two-entry queue between the front end and the decision stage
module tsdi_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             not_empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	assign pop_data  = mem_q[rd_ptr_q];
	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;

endmodule

// ===== src/tsdi_back.sv =====
// back end: burst counter, drop budgets and the result register
module tsdi_back #(
	parameter int BUDGET_BITS = 8,
	parameter int PORT_BITS   = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_index,
	input  logic [tsdi_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                q_not_empty,
	input  tsdi_pkg::cls_t                      q_cls,
	input  logic [PORT_BITS-1:0]                q_port,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                forward,
	output logic [PORT_BITS-1:0]                out_port,
	output logic [2:0]                          drop_reason
);
	import tsdi_pkg::*;

	localparam int EXT_BITS = LANES * BUDGET_BITS + CFG_DATA_BITS;

	logic [BUDGET_BITS-1:0] budget_q [2*LANES];
	logic [LEN_BITS-1:0]    burst_len_q;
	logic [LEN_BITS-1:0]    burst_cnt_q;
	logic [LEN_BITS-1:0]    burst_cnt_nxt;
	logic                   out_valid_q;
	logic                   forward_q;
	logic [PORT_BITS-1:0]   out_port_q;
	why_t                   why_q;
	why_t                   why;
	logic                   check_budget;
	logic                   budget_dec;
	logic [2:0]             slot;
	logic [EXT_BITS-1:0]    cfg_ext;

	assign cfg_ext = {{(LANES*BUDGET_BITS){1'b0}}, cfg_data};
	assign q_pop   = q_not_empty && (!out_valid_q || !out_stall);
	assign slot    = {q_cls.server_side, q_cls.kind};

	always_comb begin
		why           = q_cls.pre_why;
		check_budget  = 1'b1;
		budget_dec    = 1'b0;
		burst_cnt_nxt = burst_cnt_q;
		if (q_cls.pre_why == WHY_NONE) begin
			if (q_cls.server_side) begin
				if (burst_cnt_q != '0) begin
					check_budget = 1'b0;
					if (burst_cnt_q == burst_len_q) begin
						burst_cnt_nxt = '0;
					end else begin
						burst_cnt_nxt = burst_cnt_q + LEN_BITS'(1);
						why           = WHY_BURST;
					end
				end else if (q_cls.burst_hit) begin
					check_budget = 1'b0;
					if (burst_len_q != '0) begin
						burst_cnt_nxt = LEN_BITS'(1);
						why           = WHY_BURST;
					end
				end
			end
			if (check_budget && q_cls.budget_kind && budget_q[slot] != '0) begin
				budget_dec = 1'b1;
				why        = WHY_BUDGET;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_len_q <= '0;
			burst_cnt_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 2*LANES; i++)
				budget_q[i] <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_BURST_LEN)
				burst_len_q <= cfg_data[LEN_BITS-1:0];
			if (cfg_we && cfg_index == CFG_CLIENT_BUD) begin
				for (int i = 0; i < LANES; i++)
					budget_q[i] <= cfg_ext[i*BUDGET_BITS +: BUDGET_BITS];
			end else if (cfg_we && cfg_index == CFG_SERVER_BUD) begin
				for (int i = 0; i < LANES; i++)
					budget_q[LANES+i] <= cfg_ext[i*BUDGET_BITS +: BUDGET_BITS];
			end else if (q_pop && budget_dec) begin
				budget_q[slot] <= budget_q[slot] - BUDGET_BITS'(1);
			end
			if (q_pop)
				burst_cnt_q <= burst_cnt_nxt;
			if (q_pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			why_q      <= why;
			forward_q  <= why == WHY_NONE;
			out_port_q <= (why == WHY_NONE) ? q_port : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign forward     = forward_q;
	assign out_port    = out_port_q;
	assign drop_reason = why_q;

endmodule

// ===== src/tcp_segment_drop_injector.sv =====
// top level of the segment drop injector
//
// Input channel: in_valid / in_stall carry one frame header per beat:
// bit_error, server_side, seg_kind, dest_port and two random values.
// Output channel: out_valid / out_stall carry one decision per beat:
// forward, out_port (zero for a dropped frame) and drop_reason.
// Configuration: cfg_we writes cfg_data to register cfg_index at a clock
// edge; budget writes reload the four drop budgets of that direction.
// An accepted beat is written into the queue and popped into the result
// register when free; one beat per cycle is sustained unless stalled.
// The front end classifies each beat against the thresholds and pushes
// it into a two-entry queue; the back end does the burst counter and
// budget read-modify-write and fills the result register.
// When the receiver stalls, the result holds, the queue fills and
// in_stall rises only once both queue entries are taken.
// Reset clears thresholds, queue state, burst state, out_valid, budgets.
module tcp_segment_drop_injector #(
	parameter int BUDGET_BITS = 8,
	parameter int PORT_BITS   = 8,
	parameter int RAND_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_index,
	input  logic [tsdi_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                bit_error,
	input  logic                                server_side,
	input  logic [2:0]                          seg_kind,
	input  logic [PORT_BITS-1:0]                dest_port,
	input  logic [RAND_BITS-1:0]                rand_drop,
	input  logic [RAND_BITS-1:0]                rand_burst,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                forward,
	output logic [PORT_BITS-1:0]                out_port,
	output logic [2:0]                          drop_reason
);
	import tsdi_pkg::*;

	localparam int QW = CLS_BITS + PORT_BITS;

	cls_t                 front_cls;
	cls_t                 q_cls;
	logic [PORT_BITS-1:0] q_port;
	logic [QW-1:0]        q_data;
	logic                 q_full;
	logic                 q_not_empty;
	logic                 q_pop;
	logic                 push;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	tsdi_front #(
		.RAND_BITS (RAND_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.bit_error   (bit_error),
		.server_side (server_side),
		.seg_kind    (seg_kind),
		.rand_drop   (rand_drop),
		.rand_burst  (rand_burst),
		.cls         (front_cls)
	);

	tsdi_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({front_cls, dest_port}),
		.pop       (q_pop),
		.pop_data  (q_data),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	assign q_cls  = cls_t'(q_data[QW-1:PORT_BITS]);
	assign q_port = q_data[PORT_BITS-1:0];

	tsdi_back #(
		.BUDGET_BITS (BUDGET_BITS),
		.PORT_BITS   (PORT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_not_empty (q_not_empty),
		.q_cls       (q_cls),
		.q_port      (q_port),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.forward     (forward),
		.out_port    (out_port),
		.drop_reason (drop_reason)
	);

endmodule

// ===== src/tsdi_checker.sv =====
// port-level checks for the segment drop injector, bound to the top level
module tsdi_checker #(
	parameter int PORT_BITS = 8
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 forward,
	input logic [PORT_BITS-1:0] out_port,
	input logic [2:0]           drop_reason
);
	import tsdi_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(forward) && $stable(out_port)
			&& $stable(drop_reason))
		else $error("stalled result beat changed");

	a_fwd_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> forward == (drop_reason == WHY_NONE))
		else $error("forward flag disagrees with drop reason");

	a_drop_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !forward |-> out_port == '0)
		else $error("dropped frame carries a port");

	a_full_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

endmodule

bind tcp_segment_drop_injector tsdi_checker #(
	.PORT_BITS (PORT_BITS)
) u_tsdi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.forward     (forward),
	.out_port    (out_port),
	.drop_reason (drop_reason)
);

// ===== tb/tcp_segment_drop_injector_tb.sv =====
// testbench for the segment drop injector: random frames and settings checked against a predictor
`timescale 1ns / 100ps

module tcp_segment_drop_injector_tb;
	import tsdi_pkg::*;

	localparam logic [2:0] KIND_SYN   = 3'd0;
	localparam logic [2:0] KIND_ACK   = 3'd1;
	localparam logic [2:0] KIND_DATA  = 3'd2;
	localparam logic [2:0] KIND_OTHER = 3'd4;
	localparam logic [2:0] CFG_SPARE  = 3'd5;
	localparam int         HOLD_CYCLES = 120;
	localparam int         MAX_SHOWN   = 10;

	typedef struct {
		logic        bit_error;
		logic        server_side;
		logic [2:0]  seg_kind;
		logic [7:0]  dest_port;
		logic [15:0] rand_drop;
		logic [15:0] rand_burst;
	} frame_t;

	typedef struct {
		logic       forward;
		logic [7:0] out_port;
		why_t       why;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        bit_error = 1'b0;
	logic        server_side = 1'b0;
	logic [2:0]  seg_kind = '0;
	logic [7:0]  dest_port = '0;
	logic [15:0] rand_drop = '0;
	logic [15:0] rand_burst = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        forward;
	logic [7:0]  out_port;
	logic [2:0]  drop_reason;

	frame_t   frames_waiting[$];
	verdict_t decisions_due[$];

	logic [16:0] thr_rand = '0;
	logic [16:0] thr_burst = '0;
	logic [7:0]  burst_len = '0;
	logic [7:0]  budget[8];
	logic [7:0]  burst_cnt = '0;

	logic in_took = 1'b0;
	logic out_took = 1'b0;
	logic tx_quiet = 1'b0;
	logic rx_quiet = 1'b0;
	logic rx_hold = 1'b0;
	int   tx_gap = 0;
	int   rx_wait = 0;
	int   mismatches = 0;
	event rx_hold_go;

	tcp_segment_drop_injector dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.bit_error(bit_error),
		.server_side(server_side),
		.seg_kind(seg_kind),
		.dest_port(dest_port),
		.rand_drop(rand_drop),
		.rand_burst(rand_burst),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.forward(forward),
		.out_port(out_port),
		.drop_reason(drop_reason)
	);

	always #5 clk = ~clk;

	initial begin
		foreach (budget[i]) budget[i] = '0;
	end

	function automatic verdict_t decide_frame(frame_t f);
		why_t       why;
		logic       check;
		logic [2:0] slot;
		verdict_t   v;
		why = WHY_NONE;
		check = 1'b1;
		if (f.bit_error) begin
			why = WHY_BITERR;
		end else if ({1'b0, f.rand_drop} < thr_rand) begin
			why = WHY_RANDOM;
		end else begin
			if (f.server_side) begin
				if (burst_cnt != 0) begin
					check = 1'b0;
					if (burst_cnt == burst_len) begin
						burst_cnt = '0;
					end else begin
						burst_cnt = burst_cnt + 8'd1;
						why = WHY_BURST;
					end
				end else if ({1'b0, f.rand_burst} < thr_burst) begin
					check = 1'b0;
					if (burst_len != 0) begin
						burst_cnt = 8'd1;
						why = WHY_BURST;
					end
				end
			end
			if (check && f.seg_kind <= KIND_FIN) begin
				slot = {f.server_side, f.seg_kind[1:0]};
				if (budget[slot] != 0) begin
					budget[slot] = budget[slot] - 8'd1;
					why = WHY_BUDGET;
				end
			end
		end
		v.forward = (why == WHY_NONE);
		v.out_port = v.forward ? f.dest_port : 8'd0;
		v.why = why;
		return v;
	endfunction

	function automatic int draw_wait(logic quiet);
		if (quiet || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	// sender
	always @(negedge clk) begin : tx_side
		frame_t f;
		if (arst_n) begin
			if (in_valid && !in_took) begin
			end else if (tx_gap != 0) begin
				in_valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (frames_waiting.size() != 0) begin
				f = frames_waiting.pop_front();
				bit_error <= f.bit_error;
				server_side <= f.server_side;
				seg_kind <= f.seg_kind;
				dest_port <= f.dest_port;
				rand_drop <= f.rand_drop;
				rand_burst <= f.rand_burst;
				in_valid <= 1'b1;
				tx_gap <= draw_wait(tx_quiet);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin : rx_side
		int n;
		if (arst_n) begin
			n = out_took ? draw_wait(rx_quiet) : rx_wait;
			if (rx_hold) begin
				out_stall <= 1'b1;
			end else if (n != 0) begin
				out_stall <= 1'b1;
				n = n - 1;
			end else begin
				out_stall <= 1'b0;
			end
			rx_wait <= n;
		end
	end

	always begin
		@(rx_hold_go);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// beat monitor and decision check
	always @(posedge clk) begin : monitor
		frame_t   f;
		verdict_t e;
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			out_took <= out_valid && !out_stall;
			if (in_valid && !in_stall) begin
				f.bit_error = bit_error;
				f.server_side = server_side;
				f.seg_kind = seg_kind;
				f.dest_port = dest_port;
				f.rand_drop = rand_drop;
				f.rand_burst = rand_burst;
				decisions_due.push_back(decide_frame(f));
			end
			if (out_valid && !out_stall) begin
				if (decisions_due.size() == 0) begin
					if (mismatches < MAX_SHOWN)
						$display("unexpected beat: forward %0d port %0d reason %0d",
							forward, out_port, drop_reason);
					mismatches = mismatches + 1;
				end else begin
					e = decisions_due.pop_front();
					if (forward !== e.forward || out_port !== e.out_port ||
						drop_reason !== e.why) begin
						if (mismatches < MAX_SHOWN)
							$display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
								e.forward, e.out_port, e.why,
								forward, out_port, drop_reason);
						mismatches = mismatches + 1;
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RAND_THR:   thr_rand = val[16:0];
			CFG_BURST_THR:  thr_burst = val[16:0];
			CFG_BURST_LEN:  burst_len = val[7:0];
			CFG_CLIENT_BUD: for (int i = 0; i < 4; i++) budget[i] = val[8*i +: 8];
			CFG_SERVER_BUD: for (int i = 0; i < 4; i++) budget[4 + i] = val[8*i +: 8];
			default: ;
		endcase
	endtask

	task automatic add_frame(input logic be, input logic srv, input logic [2:0] kind,
		input logic [7:0] port, input logic [15:0] rd, input logic [15:0] rb);
		frame_t f;
		f.bit_error = be;
		f.server_side = srv;
		f.seg_kind = kind;
		f.dest_port = port;
		f.rand_drop = rd;
		f.rand_burst = rb;
		frames_waiting.push_back(f);
	endtask

	task automatic drain();
		while (frames_waiting.size() != 0 || in_valid || decisions_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_thr(int narrow);
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'h10000;
			2: return $urandom_range(0, 65536);
			default: return $urandom_range(0, narrow);
		endcase
	endfunction

	function automatic logic [31:0] pick_len();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd255;
			2: return 32'd1;
			default: return $urandom_range(0, 12);
		endcase
	endfunction

	function automatic logic [31:0] pick_budgets();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			default: return $urandom() & 32'h0707_0707;
		endcase
	endfunction

	initial begin : stimulus
		int n_items;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: everything forwards except bit errors
		add_frame(1'b0, 1'b0, KIND_SYN, 8'h00, 16'h0000, 16'h0000);
		add_frame(1'b0, 1'b1, KIND_FIN, 8'hFF, 16'hFFFF, 16'hFFFF);
		add_frame(1'b1, 1'b0, 3'd7, 8'h5A, 16'h1234, 16'h4321);
		add_frame(1'b0, 1'b1, KIND_OTHER, 8'hA5, 16'h8000, 16'h0001);
		drain();

		write_reg(CFG_RAND_THR, 32'h8000);
		write_reg(CFG_BURST_THR, 32'd0);
		write_reg(CFG_BURST_LEN, 32'd3);
		write_reg(CFG_CLIENT_BUD, 32'hFF00_0201);
		write_reg(CFG_SERVER_BUD, 32'h0000_0100);
		write_reg(CFG_SPARE, 32'hFFFF_FFFF);
		add_frame(1'b0, 1'b0, KIND_SYN, 8'h11, 16'h7FFF, 16'hFFFF);
		add_frame(1'b0, 1'b0, KIND_SYN, 8'h12, 16'h8000, 16'hFFFF);
		add_frame(1'b0, 1'b0, KIND_SYN, 8'h13, 16'hFFFF, 16'hFFFF);
		add_frame(1'b0, 1'b0, KIND_DATA, 8'h14, 16'hFFFF, 16'h0000);
		add_frame(1'b0, 1'b0, KIND_FIN, 8'hAA, 16'hFFFF, 16'h0000);
		add_frame(1'b0, 1'b1, KIND_ACK, 8'h15, 16'hFFFF, 16'h0000);
		add_frame(1'b0, 1'b1, KIND_ACK, 8'h16, 16'hFFFF, 16'h0000);
		add_frame(1'b0, 1'b0, 3'd5, 8'h17, 16'hFFFF, 16'h0000);
		drain();

		// every server frame hits the burst threshold; bursts are of length three
		write_reg(CFG_BURST_THR, 32'h10000);
		write_reg(CFG_SERVER_BUD, 32'h0101_0101);
		add_frame(1'b0, 1'b1, KIND_SYN, 8'h21, 16'hFFFF, 16'h0000);
		add_frame(1'b0, 1'b1, KIND_ACK, 8'h22, 16'hFFFF, 16'hFFFF);
		add_frame(1'b0, 1'b1, KIND_DATA, 8'h23, 16'hFFFF, 16'hFFFF);
		add_frame(1'b0, 1'b1, KIND_FIN, 8'h24, 16'hFFFF, 16'hFFFF);
		drain();

		// burst hit with zero length forwards unchecked
		write_reg(CFG_BURST_LEN, 32'd0);
		add_frame(1'b0, 1'b1, KIND_SYN, 8'h31, 16'hFFFF, 16'hFFFF);
		add_frame(1'b0, 1'b0, KIND_ACK, 8'h32, 16'hFFFF, 16'h0000);
		add_frame(1'b1, 1'b1, KIND_SYN, 8'h33, 16'hFFFF, 16'h0000);
		drain();

		// running burst, then length lowered below the count
		write_reg(CFG_BURST_LEN, 32'd4);
		write_reg(CFG_BURST_THR, 32'd1);
		add_frame(1'b0, 1'b1, KIND_DATA, 8'h41, 16'hFFFF, 16'h0000);
		add_frame(1'b0, 1'b1, KIND_DATA, 8'h42, 16'hFFFF, 16'hFFFF);
		add_frame(1'b0, 1'b1, KIND_DATA, 8'h43, 16'hFFFF, 16'hFFFF);
		drain();
		write_reg(CFG_BURST_LEN, 32'd1);
		write_reg(CFG_RAND_THR, 32'd0);

		for (int p = 0; p < 8; p++) begin
			if (p != 0) begin
				write_reg(CFG_RAND_THR, pick_thr(8192));
				write_reg(CFG_BURST_THR, pick_thr(4096));
				write_reg(CFG_BURST_LEN, pick_len());
				if ($urandom_range(0, 3) == 0)
					write_reg(CFG_SPARE + 3'($urandom_range(0, 2)), $urandom());
			end
			write_reg(CFG_CLIENT_BUD, pick_budgets());
			write_reg(CFG_SERVER_BUD, pick_budgets());
			tx_quiet = ($urandom_range(0, 2) == 0);
			rx_quiet = ($urandom_range(0, 2) == 0);
			if (p == 2) begin
				tx_quiet = 1'b1;
				@(posedge clk);
				-> rx_hold_go;
			end
			n_items = (p == 0) ? 400 : 90;
			for (int k = 0; k < n_items; k++)
				add_frame($urandom_range(0, 15) == 0,
					(p == 0) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1)),
					3'($urandom_range(0, 7)), 8'($urandom()),
					16'($urandom()), 16'($urandom()));
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && decisions_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
